/* hdl/bfsp_pkg.sv */
// Shared types and constants of the Bellman-Ford shortest-path engine.
package bfsp_pkg;

	// Field widths
	localparam int VID_W   = 6;
	localparam int WGT_W   = 16;
	localparam int DIST_W  = 24;
	localparam int VCNT_W  = 7;
	localparam int INF_W   = 23;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Saturation limits of a distance
	localparam logic signed [DIST_W-1:0] DIST_MAX = 24'sh7FFFFF;
	localparam logic signed [DIST_W-1:0] DIST_MIN = 24'sh800000;

	// Opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RUN  = 1'b1;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_VERTEX_COUNT   = 2'd0;
	localparam logic [1:0] REG_SOURCE_VERTEX  = 2'd1;
	localparam logic [1:0] REG_INFINITY_VALUE = 2'd2;

	// Register reset values
	localparam logic [VCNT_W-1:0] VERTEX_COUNT_RST   = 7'd64;
	localparam logic [VID_W-1:0]  SOURCE_VERTEX_RST  = 6'd0;
	localparam logic [INF_W-1:0]  INFINITY_VALUE_RST = 23'd10000;

	typedef struct packed {
		logic                    opcode;
		logic [VID_W-1:0]        edge_from;
		logic [VID_W-1:0]        edge_to;
		logic signed [WGT_W-1:0] edge_weight;
	} item_t;

	typedef struct packed {
		logic [VID_W-1:0]         vertex_index;
		logic signed [DIST_W-1:0] path_distance;
		logic                     has_predecessor;
		logic [VID_W-1:0]         predecessor;
		logic                     negative_cycle;
		logic                     last;
	} result_t;

	// One stored edge
	typedef struct packed {
		logic [VID_W-1:0]        edge_from;
		logic [VID_W-1:0]        edge_to;
		logic signed [WGT_W-1:0] edge_weight;
	} edge_entry_t;

	// One vertex record: predecessor and distance
	typedef struct packed {
		logic                     pred_valid;
		logic [VID_W-1:0]         pred;
		logic signed [DIST_W-1:0] path_dist;
	} dist_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_EDGE_RD,
		ST_DIST_RD,
		ST_RELAX,
		ST_EMIT_RD,
		ST_EMIT_LOAD,
		ST_EMIT_OUT
	} state_t;

endpackage

/* hdl/bfsp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module bfsp_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/bfsp_relax.sv */
// Relaxation unit: saturated distance plus weight, compared against the target distance.
module bfsp_relax (
	input  logic signed [bfsp_pkg::DIST_W-1:0] dist_from,
	input  logic signed [bfsp_pkg::DIST_W-1:0] dist_to,
	input  logic signed [bfsp_pkg::WGT_W-1:0]  weight,
	output logic signed [bfsp_pkg::DIST_W-1:0] sum,
	output logic                               improve
);

	logic signed [bfsp_pkg::DIST_W:0] wide_sum;

	// Add with one guard bit, then clamp to the distance range
	always_comb begin
		wide_sum = (bfsp_pkg::DIST_W + 1)'(dist_from) + (bfsp_pkg::DIST_W + 1)'(weight);
		if (wide_sum[bfsp_pkg::DIST_W] != wide_sum[bfsp_pkg::DIST_W-1]) begin
			sum = wide_sum[bfsp_pkg::DIST_W] ? bfsp_pkg::DIST_MIN : bfsp_pkg::DIST_MAX;
		end else begin
			sum = wide_sum[bfsp_pkg::DIST_W-1:0];
		end
		improve = (sum < dist_to);
	end

endmodule

/* hdl/bellman_ford_shortest_paths.sv */
// Bellman-Ford shortest-path engine. A load beat (opcode 0) appends one edge to the edge
// memory and the block stays ready; loads past MAX_EDGES are dropped and edges accumulate
// until reset. A run beat (opcode 1) takes the block busy: it initializes the vertex
// records, then makes n passes over the stored edges (n-1 relaxing, one checking for a
// negative cycle), reading each edge, then its two vertex records, then relaxing it unless
// an endpoint is out of range, all through one shared add/saturate/compare unit, and then
// emits one result beat per vertex plus any output stall. n is vertex_count clamped to
// 1..MAX_VERTICES. The edge list and vertex records each sit in a RAM with registered read;
// the vertex record RAM has two identical copies so both ends of an edge read together.
module bellman_ford_shortest_paths #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bfsp_pkg::PADDR_W-1:0]  paddr,
	input  logic [bfsp_pkg::PDATA_W-1:0]  pwdata,
	output logic [bfsp_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  bfsp_pkg::item_t               item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output bfsp_pkg::result_t             result
);

	localparam int VW   = $clog2(MAX_VERTICES + 1);
	localparam int AW   = $clog2(MAX_VERTICES);
	localparam int CMPW = (VW > bfsp_pkg::VCNT_W) ? VW : bfsp_pkg::VCNT_W;
	localparam int ECW  = $clog2(MAX_EDGES + 1);
	localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EW   = $bits(bfsp_pkg::edge_entry_t);
	localparam int DW   = $bits(bfsp_pkg::dist_entry_t);

	// Configuration registers
	logic [bfsp_pkg::VCNT_W-1:0] vc_q;
	logic [bfsp_pkg::VID_W-1:0]  src_q;
	logic [bfsp_pkg::INF_W-1:0]  inf_q;

	// Sequencer state and counters
	bfsp_pkg::state_t state_q, state_nxt;
	logic [VW-1:0]    n_q;
	logic [VW-1:0]    v_q;
	logic [VW-1:0]    pass_q;
	logic [ECW-1:0]   e_q;
	logic [ECW-1:0]   ecount_q;
	logic             neg_q;
	bfsp_pkg::result_t result_q;

	// Datapath nets
	logic                     cfg_wr;
	logic [VW-1:0]            n_cfg;
	logic                     run_acc;
	logic                     load_acc;
	logic                     v_last;
	logic                     edge_last;
	logic                     edge_skip;
	logic                     check_pass;
	bfsp_pkg::edge_entry_t    edge_wdata, edge_rd;
	logic                     edge_we;
	bfsp_pkg::dist_entry_t    dist_wdata, dist_rd_a, dist_rd_b;
	logic                     dist_we;
	logic [AW-1:0]            dist_waddr, dist_raddr_a, dist_raddr_b;
	logic signed [bfsp_pkg::DIST_W-1:0] relax_sum;
	logic                     relax_improve;

	// APB access
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q  <= bfsp_pkg::VERTEX_COUNT_RST;
			src_q <= bfsp_pkg::SOURCE_VERTEX_RST;
			inf_q <= bfsp_pkg::INFINITY_VALUE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				bfsp_pkg::REG_VERTEX_COUNT:   vc_q  <= pwdata[bfsp_pkg::VCNT_W-1:0];
				bfsp_pkg::REG_SOURCE_VERTEX:  src_q <= pwdata[bfsp_pkg::VID_W-1:0];
				bfsp_pkg::REG_INFINITY_VALUE: inf_q <= pwdata[bfsp_pkg::INF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			bfsp_pkg::REG_VERTEX_COUNT:   prdata = bfsp_pkg::PDATA_W'(vc_q);
			bfsp_pkg::REG_SOURCE_VERTEX:  prdata = bfsp_pkg::PDATA_W'(src_q);
			bfsp_pkg::REG_INFINITY_VALUE: prdata = bfsp_pkg::PDATA_W'(inf_q);
			default:                      prdata = '0;
		endcase
	end

	// Clamp vertex count to 1..MAX_VERTICES
	always_comb begin
		if (vc_q == '0) begin
			n_cfg = VW'(1);
		end else if (CMPW'(vc_q) > CMPW'(MAX_VERTICES)) begin
			n_cfg = VW'(MAX_VERTICES);
		end else begin
			n_cfg = VW'(vc_q);
		end
	end

	// Status terms for the sequencer
	assign run_acc    = item_valid & item_ready & (item.opcode == bfsp_pkg::OP_RUN);
	assign load_acc   = item_valid & item_ready & (item.opcode == bfsp_pkg::OP_LOAD);
	assign v_last     = (v_q == n_q - VW'(1));
	assign edge_last  = (e_q + ECW'(1) == ecount_q);
	assign check_pass = (pass_q == n_q);
	assign edge_skip  = (CMPW'(edge_rd.edge_from) >= CMPW'(n_q)) ||
	                    (CMPW'(edge_rd.edge_to) >= CMPW'(n_q));

	// Edge memory
	assign edge_wdata = '{edge_from: item.edge_from, edge_to: item.edge_to,
	                      edge_weight: item.edge_weight};

	bfsp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES), .ADDR_W(EAW)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (ecount_q[EAW-1:0]),
		.wdata (edge_wdata),
		.raddr (e_q[EAW-1:0]),
		.rdata (edge_rd)
	);

	// Vertex records, two copies: one read at the edge start, one at the edge end
	bfsp_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES), .ADDR_W(AW)) u_dist_ram_a (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (dist_wdata),
		.raddr (dist_raddr_a),
		.rdata (dist_rd_a)
	);

	bfsp_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES), .ADDR_W(AW)) u_dist_ram_b (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (dist_wdata),
		.raddr (dist_raddr_b),
		.rdata (dist_rd_b)
	);

	// Shared relaxation unit
	bfsp_relax u_relax (
		.dist_from (dist_rd_a.path_dist),
		.dist_to   (dist_rd_b.path_dist),
		.weight    (edge_rd.edge_weight),
		.sum       (relax_sum),
		.improve   (relax_improve)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bfsp_pkg::ST_IDLE: begin
				if (run_acc) state_nxt = bfsp_pkg::ST_INIT;
			end
			bfsp_pkg::ST_INIT: begin
				if (v_last) begin
					state_nxt = (ecount_q == '0) ? bfsp_pkg::ST_EMIT_RD : bfsp_pkg::ST_EDGE_RD;
				end
			end
			bfsp_pkg::ST_EDGE_RD: begin
				state_nxt = bfsp_pkg::ST_DIST_RD;
			end
			bfsp_pkg::ST_DIST_RD: begin
				if (!edge_skip) begin
					state_nxt = bfsp_pkg::ST_RELAX;
				end else if (edge_last && check_pass) begin
					state_nxt = bfsp_pkg::ST_EMIT_RD;
				end else begin
					state_nxt = bfsp_pkg::ST_EDGE_RD;
				end
			end
			bfsp_pkg::ST_RELAX: begin
				if (edge_last && check_pass) begin
					state_nxt = bfsp_pkg::ST_EMIT_RD;
				end else begin
					state_nxt = bfsp_pkg::ST_EDGE_RD;
				end
			end
			bfsp_pkg::ST_EMIT_RD: begin
				state_nxt = bfsp_pkg::ST_EMIT_LOAD;
			end
			bfsp_pkg::ST_EMIT_LOAD: begin
				state_nxt = bfsp_pkg::ST_EMIT_OUT;
			end
			bfsp_pkg::ST_EMIT_OUT: begin
				if (result_ready) begin
					state_nxt = v_last ? bfsp_pkg::ST_IDLE : bfsp_pkg::ST_EMIT_RD;
				end
			end
			default: state_nxt = bfsp_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		item_ready   = (state_q == bfsp_pkg::ST_IDLE);
		result_valid = (state_q == bfsp_pkg::ST_EMIT_OUT);
		edge_we      = load_acc && (ecount_q < ECW'(MAX_EDGES));
		dist_raddr_a = (state_q == bfsp_pkg::ST_EMIT_RD) ? v_q[AW-1:0] : AW'(edge_rd.edge_from);
		dist_raddr_b = AW'(edge_rd.edge_to);
		dist_we      = 1'b0;
		dist_waddr   = AW'(edge_rd.edge_to);
		dist_wdata   = '{pred_valid: 1'b1, pred: edge_rd.edge_from, path_dist: relax_sum};
		if (state_q == bfsp_pkg::ST_INIT) begin
			dist_we    = 1'b1;
			dist_waddr = v_q[AW-1:0];
			dist_wdata = '{pred_valid: 1'b0, pred: '0,
			               path_dist: (CMPW'(src_q) == CMPW'(v_q)) ? '0 :
			                          bfsp_pkg::DIST_W'(inf_q)};
		end else if (state_q == bfsp_pkg::ST_RELAX) begin
			dist_we = relax_improve && !check_pass;
		end
	end

	// State, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bfsp_pkg::ST_IDLE;
			n_q      <= '0;
			v_q      <= '0;
			pass_q   <= '0;
			e_q      <= '0;
			ecount_q <= '0;
			neg_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// Count stored edges
			if (edge_we) ecount_q <= ecount_q + ECW'(1);
			// Start a run
			if (run_acc) begin
				n_q    <= n_cfg;
				v_q    <= '0;
				pass_q <= VW'(1);
				e_q    <= '0;
				neg_q  <= 1'b0;
			end
			// Advance the init sweep
			if (state_q == bfsp_pkg::ST_INIT) begin
				v_q <= v_last ? '0 : v_q + VW'(1);
			end
			// Advance edge and pass
			if ((state_q == bfsp_pkg::ST_DIST_RD && edge_skip) ||
			    state_q == bfsp_pkg::ST_RELAX) begin
				if (edge_last) begin
					e_q <= '0;
					if (!check_pass) pass_q <= pass_q + VW'(1);
				end else begin
					e_q <= e_q + ECW'(1);
				end
			end
			// Flag an edge that still improves on the check pass
			if (state_q == bfsp_pkg::ST_RELAX && check_pass && relax_improve) begin
				neg_q <= 1'b1;
			end
			// Advance the result vertex
			if (state_q == bfsp_pkg::ST_EMIT_OUT && result_ready) begin
				v_q <= v_q + VW'(1);
			end
		end
	end

	// Load the output register from the record just read
	always_ff @(posedge clk) begin
		if (state_q == bfsp_pkg::ST_EMIT_LOAD) begin
			result_q.vertex_index    <= bfsp_pkg::VID_W'(v_q);
			result_q.path_distance   <= dist_rd_a.path_dist;
			result_q.has_predecessor <= dist_rd_a.pred_valid;
			result_q.predecessor     <= dist_rd_a.pred_valid ? dist_rd_a.pred : '0;
			result_q.negative_cycle  <= neg_q;
			result_q.last            <= v_last;
		end
	end

	assign result = result_q;

endmodule

/* hdl/bfsp_checker.sv */
// Port-level checker of the shortest-path engine, bound to the top level.
module bfsp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input bfsp_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_ready,
	input bfsp_pkg::result_t result
);

	// Never take items while a result is shown
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(item_ready && result_valid))
		else $error("input ready while a result is pending");

	// A run beat makes the block busy
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item.opcode == bfsp_pkg::OP_RUN) |=> !item_ready)
		else $error("ready stayed high after a run beat");

	// A load beat keeps the block ready
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item.opcode == bfsp_pkg::OP_LOAD) |=> item_ready)
		else $error("ready dropped after a load beat");

	// Each result beat is followed by a gap
	a_result_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_ready) |=> !result_valid)
		else $error("result valid right after an accepted beat");

	// Hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(result)))
		else $error("stalled result changed or dropped");

endmodule

bind bellman_ford_shortest_paths bfsp_checker u_bfsp_checker (.*);

/* tb/sv/bellman_ford_shortest_paths_tb.sv */
// Self-checking testbench for the Bellman-Ford shortest-path engine.
`timescale 1ns / 100ps

module bellman_ford_shortest_paths_tb;

	localparam int VERTEX_CAP = 64;
	localparam int EDGE_CAP   = 1024;
	localparam int REPORT_CAP = 60;

	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           psel         = 1'b0;
	logic                           penable      = 1'b0;
	logic                           pwrite       = 1'b0;
	logic [bfsp_pkg::PADDR_W-1:0]   paddr        = '0;
	logic [bfsp_pkg::PDATA_W-1:0]   pwdata       = '0;
	logic [bfsp_pkg::PDATA_W-1:0]   prdata;
	logic                           pready;
	logic                           item_valid   = 1'b0;
	logic                           item_ready;
	bfsp_pkg::item_t                item         = '0;
	logic                           result_valid;
	logic                           result_ready = 1'b0;
	bfsp_pkg::result_t              result;

	// Register copies as the engine sees them
	logic [bfsp_pkg::VCNT_W-1:0]    cfg_vertex_count = bfsp_pkg::VERTEX_COUNT_RST;
	logic [bfsp_pkg::VID_W-1:0]     cfg_source       = bfsp_pkg::SOURCE_VERTEX_RST;
	logic [bfsp_pkg::INF_W-1:0]     cfg_infinity     = bfsp_pkg::INFINITY_VALUE_RST;

	// Edge list as loaded so far
	logic [bfsp_pkg::VID_W-1:0]     edge_from_mem [EDGE_CAP];
	logic [bfsp_pkg::VID_W-1:0]     edge_to_mem [EDGE_CAP];
	int                             edge_weight_mem [EDGE_CAP];
	int                             stored_edges = 0;

	bfsp_pkg::item_t                pending_beats [$];
	bfsp_pkg::result_t              expected_paths [$];
	int                             errors = 0;
	bit                             calm = 1'b0;
	int                             gap_left;
	int                             stall_left;

	bellman_ford_shortest_paths #(
		.MAX_VERTICES(VERTEX_CAP),
		.MAX_EDGES(EDGE_CAP)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #6 clk = ~clk;

	// Idle length: mostly short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Append one edge unless the list is full
	function automatic void store_edge(bfsp_pkg::item_t beat);
		if (stored_edges < EDGE_CAP) begin
			edge_from_mem[stored_edges] = beat.edge_from;
			edge_to_mem[stored_edges] = beat.edge_to;
			edge_weight_mem[stored_edges] = $signed(beat.edge_weight);
			stored_edges++;
		end
	endfunction

	// Relax all edges n-1 times, check once more, queue one record per vertex
	function automatic void predict_shortest_paths();
		int                n;
		int                dist_v [VERTEX_CAP];
		bit                has_pred [VERTEX_CAP];
		int                pred [VERTEX_CAP];
		bit                cycle_found;
		int                a;
		int                b;
		int                sum;
		bfsp_pkg::result_t r;
		n = int'(cfg_vertex_count);
		if (n < 1) n = 1;
		if (n > VERTEX_CAP) n = VERTEX_CAP;
		cycle_found = 1'b0;
		for (int v = 0; v < n; v++) begin
			dist_v[v] = int'(cfg_infinity);
			has_pred[v] = 1'b0;
			pred[v] = 0;
		end
		if (int'(cfg_source) < n) dist_v[cfg_source] = 0;
		for (int pass = 1; pass <= n; pass++) begin
			for (int e = 0; e < stored_edges; e++) begin
				a = int'(edge_from_mem[e]);
				b = int'(edge_to_mem[e]);
				if (a < n && b < n) begin
					sum = dist_v[a] + edge_weight_mem[e];
					if (sum > int'(bfsp_pkg::DIST_MAX)) sum = int'(bfsp_pkg::DIST_MAX);
					else if (sum < int'(bfsp_pkg::DIST_MIN)) sum = int'(bfsp_pkg::DIST_MIN);
					if (sum < dist_v[b]) begin
						// last pass only looks for a further improvement
						if (pass < n) begin
							dist_v[b] = sum;
							has_pred[b] = 1'b1;
							pred[b] = a;
						end else begin
							cycle_found = 1'b1;
						end
					end
				end
			end
		end
		for (int v = 0; v < n; v++) begin
			r.vertex_index = bfsp_pkg::VID_W'(v);
			r.path_distance = bfsp_pkg::DIST_W'(dist_v[v]);
			r.has_predecessor = has_pred[v];
			r.predecessor = has_pred[v] ? bfsp_pkg::VID_W'(pred[v]) : '0;
			r.negative_cycle = cycle_found;
			r.last = (v == n - 1);
			expected_paths.push_back(r);
		end
	endfunction

	function automatic void check_value(string what, int vertex, int want, int got);
		if (want != got) begin
			errors++;
			if (errors <= REPORT_CAP)
				$display("%0t: vertex %0d %s expected %0d got %0d",
					$time, vertex, what, want, got);
		end
	endfunction

	// Compare one result beat with the oldest expected record
	function automatic void check_path(bfsp_pkg::result_t got);
		bfsp_pkg::result_t want;
		int                vtx;
		if (expected_paths.size() == 0) begin
			errors++;
			if (errors <= REPORT_CAP)
				$display("%0t: unexpected result expected none got vertex %0d distance %0d",
					$time, got.vertex_index, $signed(got.path_distance));
			return;
		end
		want = expected_paths.pop_front();
		vtx = int'(want.vertex_index);
		check_value("vertex_index", vtx, int'(want.vertex_index), int'(got.vertex_index));
		check_value("path_distance", vtx, int'($signed(want.path_distance)),
			int'($signed(got.path_distance)));
		check_value("has_predecessor", vtx, int'(want.has_predecessor),
			int'(got.has_predecessor));
		check_value("predecessor", vtx, int'(want.predecessor), int'(got.predecessor));
		check_value("negative_cycle", vtx, int'(want.negative_cycle),
			int'(got.negative_cycle));
		check_value("last", vtx, int'(want.last), int'(got.last));
	endfunction

	// Item driver: predict on each accepted beat, then present the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (item_valid && item_ready) begin
				if (item.opcode == bfsp_pkg::OP_RUN) predict_shortest_paths();
				else store_edge(item);
			end
			if (!item_valid || item_ready) begin
				if (gap_left > 0 || pending_beats.size() == 0) begin
					if (gap_left > 0) gap_left--;
					item_valid <= 1'b0;
				end else begin
					item <= pending_beats.pop_front();
					item_valid <= 1'b1;
					gap_left = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
				end
			end
		end
	end

	// Result monitor: check each beat, stall ready at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_valid && result_ready) check_path(result);
			if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				stall_left = idle_len() - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// APB write: setup cycle, then access cycle
	task automatic write_reg(input logic [1:0] idx, input logic [bfsp_pkg::PDATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		unique case (idx)
			bfsp_pkg::REG_VERTEX_COUNT: cfg_vertex_count = value[bfsp_pkg::VCNT_W-1:0];
			bfsp_pkg::REG_SOURCE_VERTEX: cfg_source = value[bfsp_pkg::VID_W-1:0];
			bfsp_pkg::REG_INFINITY_VALUE: cfg_infinity = value[bfsp_pkg::INF_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input int vc, input int src, input int inf);
		write_reg(bfsp_pkg::REG_VERTEX_COUNT, bfsp_pkg::PDATA_W'(vc));
		write_reg(bfsp_pkg::REG_SOURCE_VERTEX, bfsp_pkg::PDATA_W'(src));
		write_reg(bfsp_pkg::REG_INFINITY_VALUE, bfsp_pkg::PDATA_W'(inf));
	endtask

	// Hold until every beat is sent and every result is back
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_beats.size() != 0 || item_valid || expected_paths.size() != 0);
		repeat (10) @(negedge clk);
	endtask

	function automatic bfsp_pkg::item_t edge_beat(input int from, input int to, input int w);
		bfsp_pkg::item_t beat;
		beat.opcode = bfsp_pkg::OP_LOAD;
		beat.edge_from = bfsp_pkg::VID_W'(from);
		beat.edge_to = bfsp_pkg::VID_W'(to);
		beat.edge_weight = bfsp_pkg::WGT_W'(w);
		return beat;
	endfunction

	function automatic bfsp_pkg::item_t run_beat();
		bfsp_pkg::item_t beat;
		beat.opcode = bfsp_pkg::OP_RUN;
		beat.edge_from = bfsp_pkg::VID_W'($urandom);
		beat.edge_to = bfsp_pkg::VID_W'($urandom);
		beat.edge_weight = bfsp_pkg::WGT_W'($urandom);
		return beat;
	endfunction

	// Low vertices get only non-negative edges into 4..15, so small graphs stay
	// free of negative cycles; anything touching a high vertex is unrestricted.
	function automatic bfsp_pkg::item_t random_edge();
		int from;
		int to;
		int w;
		int r;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 60) begin
			from = $urandom_range(0, 15);
			to = $urandom_range(4, 15);
			if (r < 5) w = 0;
			else if (r < 10) w = 32767;
			else w = $urandom_range(0, 32767);
		end else begin
			from = $urandom_range(0, 63);
			to = $urandom_range(0, 63);
			if (from < 16 && to < 16) from += 16;
			if (r < 5) w = -32768;
			else if (r < 10) w = 32767;
			else if (r < 13) w = -1;
			else w = $signed(bfsp_pkg::WGT_W'($urandom));
		end
		return edge_beat(from, to, w);
	endfunction

	initial begin : stimulus
		int vc;
		int src;
		int inf;
		int n_eff;
		int r;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Small chain with extreme weights and out-of-range endpoints
		configure(5, 0, 10000);
		pending_beats.push_back(edge_beat(0, 1, 32767));
		pending_beats.push_back(edge_beat(1, 2, -32768));
		pending_beats.push_back(edge_beat(0, 2, 5));
		pending_beats.push_back(edge_beat(2, 3, -1));
		pending_beats.push_back(edge_beat(3, 4, 0));
		pending_beats.push_back(edge_beat(63, 63, 100));
		pending_beats.push_back(edge_beat(4, 40, -7));
		pending_beats.push_back(run_beat());
		wait_idle();

		// Zero vertex count runs as a single vertex
		configure(0, 0, 10000);
		pending_beats.push_back(run_beat());
		wait_idle();

		// Oversized count, top source, largest infinity, self-loop driving a
		// negative cycle down to the lower saturation bound
		configure(127, 63, 8388607);
		repeat (8) pending_beats.push_back(edge_beat(62, 62, -32768));
		pending_beats.push_back(edge_beat(63, 62, 32767));
		pending_beats.push_back(run_beat());
		wait_idle();

		// Source outside the graph, zero infinity
		configure(4, 10, 0);
		pending_beats.push_back(run_beat());
		wait_idle();

		// Random phases, each with fresh settings
		for (int ph = 0; ph < 9; ph++) begin
			calm = (ph % 4 == 2);
			r = $urandom_range(0, 99);
			if (r < 55) vc = $urandom_range(2, 16);
			else if (r < 80) vc = $urandom_range(17, 40);
			else if (r < 90) vc = $urandom_range(41, 64);
			else begin
				case ($urandom_range(0, 3))
					0: vc = 0;
					1: vc = 1;
					2: vc = 64;
					default: vc = 127;
				endcase
			end
			n_eff = (vc < 1) ? 1 : (vc > VERTEX_CAP ? VERTEX_CAP : vc);
			src = ($urandom_range(0, 3) != 0) ? $urandom_range(0, n_eff - 1)
				: $urandom_range(0, 63);
			r = $urandom_range(0, 99);
			if (r < 40) inf = 10000;
			else if (r < 60) inf = $urandom_range(0, 8388607);
			else if (r < 75) inf = 0;
			else if (r < 90) inf = 8388607;
			else inf = $urandom_range(0, 1000);
			configure(vc, src, inf);
			for (int k = 0; k < 20; k++)
				pending_beats.push_back(($urandom_range(0, 99) < 8) ? run_beat()
					: random_edge());
			pending_beats.push_back(run_beat());
			wait_idle();
		end
		calm = 1'b0;

		// Two-vertex graph with the source at the top
		configure(2, 1, 10000);
		pending_beats.push_back(edge_beat(1, 0, -3));
		pending_beats.push_back(run_beat());
		wait_idle();

		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(64'd100_000_000);
		$display("simulation failed");
		$finish;
	end

endmodule

/* sim.f */
hdl/bfsp_pkg.sv
hdl/bfsp_ram.sv
hdl/bfsp_relax.sv
hdl/bellman_ford_shortest_paths.sv
hdl/bfsp_checker.sv
tb/sv/bellman_ford_shortest_paths_tb.sv
